FILE: hdl/m2inv_pkg.sv
// Shared types, constants, rounding and lzc helpers for the 2x2 matrix inverse core.
package m2inv_pkg;

  // Unpacked single-precision value: unbiased exponent, 24-bit mantissa with hidden bit.
  typedef struct packed {
    logic              sgn;
    logic              zero;
    logic signed [8:0] exp;
    logic [23:0]       man;
  } fp_t;

  // The four matrix elements in column-major order.
  typedef fp_t [3:0] quad_t;

  localparam logic [31:0] CanonNan   = 32'h7FC0_0000;
  localparam logic [7:0]  ExpBias    = 8'd127;
  localparam logic [23:0] ManOne     = 24'h80_0000;
  localparam logic [25:0] RcpInit    = 26'h100_0000;
  localparam int          RcpStages  = 25;

  // Round to nearest even; a carry out of the mantissa bumps the exponent.
  function automatic fp_t fp_round(logic sgn, logic signed [8:0] exp, logic [23:0] man,
                                   logic grd, logic sticky);
    logic        up;
    logic [24:0] sum;
    fp_t         f;
    up     = grd & (sticky | man[0]);
    sum    = {1'b0, man} + {24'd0, up};
    f.sgn  = sgn;
    f.zero = 1'b0;
    if (sum[24]) begin
      f.man = sum[24:1];
      f.exp = exp + 9'sd1;
    end else begin
      f.man = sum[23:0];
      f.exp = exp;
    end
    return f;
  endfunction

  // Normalize and round a 48-bit mantissa product lying in [2^46, 2^48).
  function automatic fp_t fp_mul_norm(logic sgn, logic zero, logic signed [8:0] exp,
                                      logic [47:0] p);
    fp_t f;
    if (p[47]) begin
      f = fp_round(sgn, exp + 9'sd1, p[47:24], p[23], |p[22:0]);
    end else begin
      f = fp_round(sgn, exp, p[46:23], p[22], |p[21:0]);
    end
    f.zero = zero;
    return f;
  endfunction

  // Leading zero count of a 32-bit word; 32 for zero.
  function automatic logic [5:0] lzc32(logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // Leading zero count of a 64-bit word; 64 for zero.
  function automatic logic [6:0] lzc64(logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

FILE: hdl/matrix2x2_int_to_float_inverse_core.sv
// Top level of the pipelined 2x2 integer-matrix to single-precision inverse core.
//
//  Channel   Handshake          Payload
//  --------  -----------------  -------------------------------------------------
//  request   start / busy       in_elem_r0c0, in_elem_r1c0, in_elem_r0c1, in_elem_r1c1
//  result    out_valid strobe   out_inv_r0c0, out_inv_r1c0, out_inv_r0c1, out_inv_r1c1
//
// A request is taken on every cycle that start is high; busy is always low.
// Each result appears as a one-cycle out_valid strobe.
// The pipeline comprises the 25-stage restoring divider for the reciprocal, plus
// conversion (2), determinant (7), reciprocal rounding (1) and output (2) stages.
// Synchronous reset clears only the valid bits; the receiver cannot stall the pipe.
module matrix2x2_int_to_float_inverse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_elem_r0c0,
  input  logic signed [31:0] in_elem_r1c0,
  input  logic signed [31:0] in_elem_r0c1,
  input  logic signed [31:0] in_elem_r1c1,
  output logic               out_valid,
  output logic [31:0]        out_inv_r0c0,
  output logic [31:0]        out_inv_r1c0,
  output logic [31:0]        out_inv_r0c1,
  output logic [31:0]        out_inv_r1c1
);
  import m2inv_pkg::*;

  logic  cvt_vld, det_vld, rcp_vld, rinf;
  quad_t cvt_quad, det_quad, rcp_quad;
  fp_t   det, rcp;

  // The pipeline never holds off a request.
  assign busy = 1'b0;

  m2inv_cvt u_cvt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start),
    .e0_i   (in_elem_r0c0),
    .e1_i   (in_elem_r1c0),
    .e2_i   (in_elem_r0c1),
    .e3_i   (in_elem_r1c1),
    .vld_o  (cvt_vld),
    .quad_o (cvt_quad)
  );

  m2inv_det u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (cvt_vld),
    .quad_i (cvt_quad),
    .vld_o  (det_vld),
    .det_o  (det),
    .quad_o (det_quad)
  );

  m2inv_rcp u_rcp (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (det_vld),
    .det_i  (det),
    .quad_i (det_quad),
    .vld_o  (rcp_vld),
    .rcp_o  (rcp),
    .rinf_o (rinf),
    .quad_o (rcp_quad)
  );

  m2inv_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (rcp_vld),
    .rcp_i  (rcp),
    .rinf_i (rinf),
    .quad_i (rcp_quad),
    .vld_o  (out_valid),
    .o0_o   (out_inv_r0c0),
    .o1_o   (out_inv_r1c0),
    .o2_o   (out_inv_r0c1),
    .o3_o   (out_inv_r1c1)
  );

endmodule

FILE: hdl/m2inv_cvt.sv
// Integer to single-precision conversion of the four matrix elements, two stages.
module m2inv_cvt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic signed [31:0]  e0_i,
  input  logic signed [31:0]  e1_i,
  input  logic signed [31:0]  e2_i,
  input  logic signed [31:0]  e3_i,
  output logic                vld_o,
  output m2inv_pkg::quad_t    quad_o
);
  import m2inv_pkg::*;

  logic [31:0]       elem [4];
  logic [31:0]       mag  [4];
  logic [5:0]        lz   [4];
  logic [31:0]       norm_nxt [4];
  logic [31:0]       norm_r [4];
  logic signed [8:0] exp_r  [4];
  logic [3:0]        sgn_r, zero_r;
  logic              vld1_r, vld2_r;
  quad_t             quad_nxt, quad_r;

  assign elem[0] = e0_i;
  assign elem[1] = e1_i;
  assign elem[2] = e2_i;
  assign elem[3] = e3_i;

  // Stage 1: magnitude, leading zero count and left alignment.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]      = elem[i][31] ? (~elem[i] + 32'd1) : elem[i];
      lz[i]       = lzc32(mag[i]);
      norm_nxt[i] = mag[i] << lz[i][4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    for (int i = 0; i < 4; i++) begin
      norm_r[i] <= norm_nxt[i];
      exp_r[i]  <= 9'sd31 - $signed({3'b000, lz[i]});
      sgn_r[i]  <= elem[i][31];
      zero_r[i] <= (mag[i] == 32'd0);
    end
  end

  // Stage 2: round the top 24 bits to nearest even.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quad_nxt[i]      = fp_round(sgn_r[i], exp_r[i], norm_r[i][31:8], norm_r[i][7],
                                  |norm_r[i][6:0]);
      quad_nxt[i].zero = zero_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    quad_r <= quad_nxt;
  end

  assign vld_o  = vld2_r;
  assign quad_o = quad_r;

endmodule

FILE: hdl/m2inv_det.sv
// Determinant pipeline: two rounded products, exact difference, rounding to single.
module m2inv_det (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  m2inv_pkg::quad_t   quad_i,
  output logic               vld_o,
  output m2inv_pkg::fp_t     det_o,
  output m2inv_pkg::quad_t   quad_o
);
  import m2inv_pkg::*;

  logic [6:0] vld_r;
  quad_t      quad_r [7];

  // Stage 1: mantissa products.
  logic [47:0]       p0_r, p1_r;
  logic              ps0_r, ps1_r, pz0_r, pz1_r;
  logic signed [8:0] pe0_r, pe1_r;

  always_ff @(posedge clk) begin
    p0_r  <= quad_i[0].man * quad_i[3].man;
    p1_r  <= quad_i[1].man * quad_i[2].man;
    ps0_r <= quad_i[0].sgn ^ quad_i[3].sgn;
    ps1_r <= quad_i[1].sgn ^ quad_i[2].sgn;
    pz0_r <= quad_i[0].zero | quad_i[3].zero;
    pz1_r <= quad_i[1].zero | quad_i[2].zero;
    pe0_r <= quad_i[0].exp + quad_i[3].exp;
    pe1_r <= quad_i[1].exp + quad_i[2].exp;
  end

  // Stage 2: round both products.
  fp_t pr0_r, pr1_r;

  always_ff @(posedge clk) begin
    pr0_r <= fp_mul_norm(ps0_r, pz0_r, pe0_r, p0_r);
    pr1_r <= fp_mul_norm(ps1_r, pz1_r, pe1_r, p1_r);
  end

  // Stage 3: products are integers; expand them to signed 65-bit values.
  logic [63:0]        int0, int1;
  logic signed [64:0] v0_nxt, v1_nxt, v0_r, v1_r;
  logic               zs_r;

  always_comb begin
    if (pr0_r.exp >= 9'sd23) begin
      int0 = {40'd0, pr0_r.man} << 6'(pr0_r.exp - 9'sd23);
    end else begin
      int0 = {40'd0, pr0_r.man} >> 5'(9'sd23 - pr0_r.exp);
    end
    if (pr1_r.exp >= 9'sd23) begin
      int1 = {40'd0, pr1_r.man} << 6'(pr1_r.exp - 9'sd23);
    end else begin
      int1 = {40'd0, pr1_r.man} >> 5'(9'sd23 - pr1_r.exp);
    end
    if (pr0_r.zero) begin
      v0_nxt = '0;
    end else begin
      v0_nxt = pr0_r.sgn ? -$signed({1'b0, int0}) : $signed({1'b0, int0});
    end
    if (pr1_r.zero) begin
      v1_nxt = '0;
    end else begin
      v1_nxt = pr1_r.sgn ? -$signed({1'b0, int1}) : $signed({1'b0, int1});
    end
  end

  always_ff @(posedge clk) begin
    v0_r <= v0_nxt;
    v1_r <= v1_nxt;
    // Only (-0) - (+0) gives a negative zero.
    zs_r <= pr0_r.zero & pr1_r.zero & pr0_r.sgn & ~pr1_r.sgn;
  end

  // Stage 4: exact difference.
  logic signed [64:0] diff_r;
  logic               zs4_r;

  always_ff @(posedge clk) begin
    diff_r <= v0_r - v1_r;
    zs4_r  <= zs_r;
  end

  // Stage 5: sign and magnitude.
  logic [63:0] mag_r;
  logic        dsg_r, dz_r, zs5_r;
  logic [64:0] neg_diff;

  assign neg_diff = -diff_r;

  always_ff @(posedge clk) begin
    mag_r <= diff_r[64] ? neg_diff[63:0] : diff_r[63:0];
    dsg_r <= diff_r[64];
    dz_r  <= (diff_r == '0);
    zs5_r <= zs4_r;
  end

  // Stage 6: normalize.
  logic [6:0]        lz;
  logic [63:0]       nrm_r;
  logic signed [8:0] dexp_r;
  logic              dsg6_r, dz6_r, zs6_r;

  assign lz = lzc64(mag_r);

  always_ff @(posedge clk) begin
    nrm_r  <= mag_r << lz[5:0];
    dexp_r <= 9'sd63 - $signed({2'b00, lz});
    dsg6_r <= dsg_r;
    dz6_r  <= dz_r;
    zs6_r  <= zs5_r;
  end

  // Stage 7: round the determinant.
  fp_t det_nxt, det_r;

  always_comb begin
    det_nxt = fp_round(dsg6_r, dexp_r, nrm_r[63:40], nrm_r[39], |nrm_r[38:0]);
    if (dz6_r) begin
      det_nxt.zero = 1'b1;
      det_nxt.sgn  = zs6_r;
    end
  end

  always_ff @(posedge clk) begin
    det_r <= det_nxt;
  end

  // Valid bits and element side data travel with each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], vld_i};
    end
    quad_r[0] <= quad_i;
    for (int k = 1; k < 7; k++) begin
      quad_r[k] <= quad_r[k-1];
    end
  end

  assign vld_o  = vld_r[6];
  assign det_o  = det_r;
  assign quad_o = quad_r[6];

endmodule

FILE: hdl/m2inv_rcp.sv
// Reciprocal of the determinant: one restoring-division bit per stage, then rounding.
module m2inv_rcp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  m2inv_pkg::fp_t     det_i,
  input  m2inv_pkg::quad_t   quad_i,
  output logic               vld_o,
  output m2inv_pkg::fp_t     rcp_o,
  output logic               rinf_o,
  output m2inv_pkg::quad_t   quad_o
);
  import m2inv_pkg::*;

  logic [RcpStages-1:0] vld_r;
  logic [25:0]          rem_r  [RcpStages];
  logic [24:0]          quo_r  [RcpStages];
  fp_t                  det_r  [RcpStages];
  quad_t                quad_r [RcpStages];

  // Quotient floor(2^48 / m) for a mantissa m in (2^23, 2^24), MSB first.
  for (genvar k = 0; k < RcpStages; k++) begin : g_stg
    logic [25:0] rem_in;
    logic [24:0] quo_in;
    fp_t         det_in;
    quad_t       quad_in;
    logic        vld_in;
    logic [26:0] dif;
    logic        qb;
    logic [25:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = RcpInit;
      assign quo_in  = '0;
      assign det_in  = det_i;
      assign quad_in = quad_i;
      assign vld_in  = vld_i;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign det_in  = det_r[k-1];
      assign quad_in = quad_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      dif     = {1'b0, rem_in} - {3'b000, det_in.man};
      qb      = ~dif[26];
      rem_nxt = qb ? {dif[24:0], 1'b0} : {rem_in[24:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= {quo_in[23:0], qb};
      det_r[k]  <= det_in;
      quad_r[k] <= quad_in;
    end
  end

  // Final stage: round the quotient; a power-of-two mantissa has an exact reciprocal.
  fp_t               last_det;
  logic [24:0]       last_quo;
  fp_t               rcp_nxt, rcp_r;
  logic              rinf_r, vldo_r;
  quad_t             quado_r;

  assign last_det = det_r[RcpStages-1];
  assign last_quo = quo_r[RcpStages-1];

  always_comb begin
    if (last_det.man == ManOne) begin
      rcp_nxt.sgn  = last_det.sgn;
      rcp_nxt.zero = 1'b0;
      rcp_nxt.exp  = -last_det.exp;
      rcp_nxt.man  = ManOne;
    end else begin
      rcp_nxt = fp_round(last_det.sgn, -last_det.exp - 9'sd1, last_quo[24:1], last_quo[0],
                         rem_r[RcpStages-1] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldo_r <= 1'b0;
    end else begin
      vldo_r <= vld_r[RcpStages-1];
    end
    rcp_r   <= rcp_nxt;
    rinf_r  <= last_det.zero;
    quado_r <= quad_r[RcpStages-1];
  end

  assign vld_o  = vldo_r;
  assign rcp_o  = rcp_r;
  assign rinf_o = rinf_r;
  assign quad_o = quado_r;

endmodule

FILE: hdl/m2inv_out.sv
// Output scaling: four element-by-reciprocal products, rounding and IEEE packing.
module m2inv_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  m2inv_pkg::fp_t     rcp_i,
  input  logic               rinf_i,
  input  m2inv_pkg::quad_t   quad_i,
  output logic               vld_o,
  output logic [31:0]        o0_o,
  output logic [31:0]        o1_o,
  output logic [31:0]        o2_o,
  output logic [31:0]        o3_o
);
  import m2inv_pkg::*;

  // Output k scales element src[k]; the middle two are negated.
  fp_t               src [4];
  logic [3:0]        neg;
  logic [47:0]       p_r [4];
  logic [3:0]        s_r, z_r;
  logic signed [8:0] e_r [4];
  logic              rinf_r, vld1_r, vld2_r;

  assign src[0] = quad_i[3];
  assign src[1] = quad_i[1];
  assign src[2] = quad_i[2];
  assign src[3] = quad_i[0];
  assign neg    = 4'b0110;

  // Stage 1: mantissa products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    for (int i = 0; i < 4; i++) begin
      p_r[i] <= src[i].man * rcp_i.man;
      s_r[i] <= src[i].sgn ^ neg[i] ^ rcp_i.sgn;
      z_r[i] <= src[i].zero;
      e_r[i] <= src[i].exp + rcp_i.exp;
    end
    rinf_r <= rinf_i;
  end

  // Stage 2: round and pack, with infinity and NaN for a singular matrix.
  fp_t         f   [4];
  logic [31:0] pk  [4];
  logic [31:0] res_r [4];
  logic [8:0]  bexp [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f[i]    = fp_mul_norm(s_r[i], z_r[i], e_r[i], p_r[i]);
      bexp[i] = 9'(f[i].exp) + {1'b0, ExpBias};
      if (rinf_r) begin
        pk[i] = z_r[i] ? CanonNan : {s_r[i], 8'hFF, 23'd0};
      end else if (z_r[i]) begin
        pk[i] = {s_r[i], 31'd0};
      end else begin
        pk[i] = {f[i].sgn, bexp[i][7:0], f[i].man[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    for (int i = 0; i < 4; i++) begin
      res_r[i] <= pk[i];
    end
  end

  assign vld_o = vld2_r;
  assign o0_o  = res_r[0];
  assign o1_o  = res_r[1];
  assign o2_o  = res_r[2];
  assign o3_o  = res_r[3];

endmodule
